/* rtl/itrd_pkg.sv */
// Package for the integer to radix digit converter.
// Holds widths, radix limits, control and status structs and the digit encoder.
// Used by itrd_div and integer_to_radix_digits_unit; depends on nothing.
package itrd_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int BASE_W      = 6;
  localparam int CHAR_W      = 7;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);

  localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);
  localparam logic [CHAR_W-1:0] ERR_CHAR = '0;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Commands from the sequencer to the divider.
  typedef struct packed {
    logic load;   // start on a fresh value and radix
    logic again;  // divide the quotient just produced once more
  } div_ctl_t;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic              quot_nz;
    logic [BASE_W-1:0] rem;
  } div_st_t;

  // Remainder 0..35 to '0'..'9', 'a'..'z'.
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [BASE_W-1:0] rem);
    logic [CHAR_W-1:0] r7;
    r7 = CHAR_W'(rem);
    if (rem < BASE_W'(10)) begin
      return CHAR_W'(7'h30) + r7;
    end else begin
      return CHAR_W'(7'h61) + r7 - CHAR_W'(10);
    end
  endfunction

endpackage

/* rtl/itrd_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle by a 6-bit radix.
// Keeps the quotient in place so the next digit can be divided out again.
// Depends on itrd_pkg.
module itrd_div (
  input  logic                             clk,
  input  logic                             rst,
  input  itrd_pkg::div_ctl_t               ctl,
  input  logic [itrd_pkg::VALUE_WIDTH-1:0] value,
  input  logic [itrd_pkg::BASE_W-1:0]      base,
  output itrd_pkg::div_st_t                st
);

  logic [itrd_pkg::VALUE_WIDTH-1:0] quot;
  logic [itrd_pkg::BASE_W-1:0]      rem;
  logic [itrd_pkg::BASE_W-1:0]      base_r;
  logic [itrd_pkg::CNT_W-1:0]       cnt;
  logic                             busy;
  logic                             done;
  logic                             quot_nz;

  logic [itrd_pkg::BASE_W:0]        rem_sh;
  logic [itrd_pkg::BASE_W:0]        rem_sub;
  logic                             ge;

  always_comb begin
    rem_sh  = {rem, quot[itrd_pkg::VALUE_WIDTH-1]};
    ge      = rem_sh >= {1'b0, base_r};
    rem_sub = rem_sh - {1'b0, base_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
      quot_nz <= 1'b0;
    end else if (ctl.load || ctl.again) begin
      busy    <= 1'b1;
      done    <= 1'b0;
      cnt     <= '0;
      quot_nz <= 1'b0;
    end else if (busy) begin
      cnt     <= cnt + itrd_pkg::CNT_W'(1);
      quot_nz <= quot_nz | ge;
      if (cnt == itrd_pkg::CNT_W'(itrd_pkg::VALUE_WIDTH - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // When the shifted remainder is below the radix it already fits BASE_W bits.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      quot   <= value;
      base_r <= base;
      rem    <= '0;
    end else if (ctl.again) begin
      rem <= '0;
    end else if (busy) begin
      quot <= {quot[itrd_pkg::VALUE_WIDTH-2:0], ge};
      rem  <= ge ? rem_sub[itrd_pkg::BASE_W-1:0] : rem_sh[itrd_pkg::BASE_W-1:0];
    end
  end

  assign st.busy    = busy;
  assign st.done    = done;
  assign st.quot_nz = quot_nz;
  assign st.rem     = rem;

endmodule

/* rtl/integer_to_radix_digits_unit.sv */
// Integer to radix digit converter, top level.
// Instantiates itrd_div; depends on itrd_pkg.
//
// Usage: a request on the input channel (in_valid/in_ready) carries a 64-bit
// unsigned value and a 6-bit radix. The block answers with one request per
// digit on the output channel (out_valid/out_ready): lower-case ASCII, least
// significant digit first, last set on the final digit. A value of zero
// gives the single digit '0'. A radix outside 2 to 36 gives one request with
// error and last set and digit_char zero.
// Each digit is divided out bit by bit in the serial divider and then moved
// into the output register. An error result appears in the cycle after its
// request is accepted.
// Items are converted one at a time; the next input request is taken once
// the final digit of the previous one has entered the output register and
// that register is free or being emptied.
// When the receiver stalls, the divider finishes the digit in progress and
// waits with it until the output register frees up.
// Reset clears the sequencer, the divider's busy, done and count state and the output valid.
module integer_to_radix_digits_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [itrd_pkg::VALUE_WIDTH-1:0] value,
  input  logic [itrd_pkg::BASE_W-1:0]      base,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [itrd_pkg::CHAR_W-1:0]      digit_char,
  output logic                             last,
  output logic                             error
);

  itrd_pkg::state_t   state;
  itrd_pkg::state_t   state_next;
  itrd_pkg::div_ctl_t div_ctl;
  itrd_pkg::div_st_t  div_st;

  logic out_free;
  logic base_bad;
  logic load_err;
  logic load_dig;

  itrd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .ctl   (div_ctl),
    .value (value),
    .base  (base),
    .st    (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itrd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    out_free   = !out_valid || out_ready;
    base_bad   = (base < itrd_pkg::BASE_MIN) || (base > itrd_pkg::BASE_MAX);
    in_ready   = (state == itrd_pkg::ST_IDLE) && out_free;
    state_next = state;
    div_ctl    = '0;
    load_err   = 1'b0;
    load_dig   = 1'b0;
    unique case (state)
      itrd_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (base_bad) begin
            load_err = 1'b1;
          end else begin
            div_ctl.load = 1'b1;
            state_next   = itrd_pkg::ST_RUN;
          end
        end
      end
      itrd_pkg::ST_RUN: begin
        if (div_st.done && out_free) begin
          load_dig = 1'b1;
          if (div_st.quot_nz) begin
            div_ctl.again = 1'b1;
          end else begin
            state_next = itrd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = itrd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_err || load_dig) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_err) begin
      digit_char <= itrd_pkg::ERR_CHAR;
      last       <= 1'b1;
      error      <= 1'b1;
    end else if (load_dig) begin
      digit_char <= itrd_pkg::digit_ascii(div_st.rem);
      last       <= !div_st.quot_nz;
      error      <= 1'b0;
    end
  end

  // An error result is always a lone final result with a zero character.
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> last && (digit_char == itrd_pkg::ERR_CHAR))
    else $error("error result without last or with a nonzero character");

  // A new request is never taken while the divider is still working.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !div_st.busy && !div_ctl.again)
    else $error("input request accepted while a conversion is in progress");

  // The final digit returns the sequencer to idle; any other digit restarts the divider.
  a_final_digit: assert property (@(posedge clk) disable iff (rst)
    load_dig |=> (last == (state == itrd_pkg::ST_IDLE)) && (last != div_st.busy))
    else $error("sequencer out of step with the last flag");

endmodule

/* tb/sv/integer_to_radix_digits_unit_tb.sv */
// Testbench for integer_to_radix_digits_unit: directed and random conversions under
// several idling patterns, with each digit checked against an in-bench digit predictor.
// Depends on itrd_pkg and the integer_to_radix_digits_unit RTL.
`timescale 1ns / 100ps

module integer_to_radix_digits_unit_tb;

  localparam int    CYCLE_LIMIT  = 8_000_000;
  localparam int    DRAIN_CYCLES = 150;
  localparam string DIGIT_SET    = "0123456789abcdefghijklmnopqrstuvwxyz";
  localparam logic [itrd_pkg::VALUE_WIDTH-1:0] ALL_ONES = '1;

  typedef struct {
    logic [itrd_pkg::CHAR_W-1:0] digit_char;
    logic                        last;
    logic                        error;
  } digit_rec_t;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             in_valid  = 1'b0;
  logic                             in_ready;
  logic [itrd_pkg::VALUE_WIDTH-1:0] value     = '0;
  logic [itrd_pkg::BASE_W-1:0]      base      = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [itrd_pkg::CHAR_W-1:0]      digit_char;
  logic                             last;
  logic                             error;

  digit_rec_t pending_digits[$];
  digit_rec_t oldest_digit;
  int         mismatch_count = 0;
  int         cycle_count    = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;

  integer_to_radix_digits_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .base      (base),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .digit_char(digit_char),
    .last      (last),
    .error     (error)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Expected digits of one conversion, least significant first.
  function automatic void predict_digits(input logic [itrd_pkg::VALUE_WIDTH-1:0] v,
                                         input logic [itrd_pkg::BASE_W-1:0] b);
    logic [itrd_pkg::VALUE_WIDTH-1:0] quot;
    logic [itrd_pkg::VALUE_WIDTH-1:0] radix;
    int                               rem;
    digit_rec_t                       rec;
    if (b < itrd_pkg::BASE_MIN || b > itrd_pkg::BASE_MAX) begin
      rec.digit_char = itrd_pkg::ERR_CHAR;
      rec.last       = 1'b1;
      rec.error      = 1'b1;
      pending_digits.push_back(rec);
    end else begin
      quot  = v;
      radix = itrd_pkg::VALUE_WIDTH'(b);
      // A zero value still produces one digit, so test after the first division.
      do begin
        rem            = int'(quot % radix);
        quot           = quot / radix;
        rec.digit_char = itrd_pkg::CHAR_W'(DIGIT_SET[rem]);
        rec.last       = (quot == '0);
        rec.error      = 1'b0;
        pending_digits.push_back(rec);
      end while (quot != '0);
    end
  endfunction

  // Receiver: checks each accepted digit and drives out_ready with random stalls.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected digit_char %h last %b error %b", $time,
                 digit_char, last, error);
        mismatch_count++;
      end else begin
        oldest_digit = pending_digits.pop_front();
        if (digit_char !== oldest_digit.digit_char) begin
          $display("%0t: digit_char expected %h got %h", $time,
                   oldest_digit.digit_char, digit_char);
          mismatch_count++;
        end
        if (last !== oldest_digit.last) begin
          $display("%0t: last expected %b got %b", $time, oldest_digit.last, last);
          mismatch_count++;
        end
        if (error !== oldest_digit.error) begin
          $display("%0t: error expected %b got %b", $time, oldest_digit.error, error);
          mismatch_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Sends one request; returns in the time step of its acceptance.
  task automatic send_conversion(input logic [itrd_pkg::VALUE_WIDTH-1:0] v,
                                 input logic [itrd_pkg::BASE_W-1:0] b);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    base     <= b;
    do @(posedge clk); while (!in_ready);
    predict_digits(v, b);
  endtask

  function automatic logic [itrd_pkg::VALUE_WIDTH-1:0] random_value();
    logic [itrd_pkg::VALUE_WIDTH-1:0] r;
    r = {$urandom, $urandom};
    unique case ($urandom_range(7, 0))
      0:       return '0;
      1, 2:    return r;
      default: return r >> $urandom_range(itrd_pkg::VALUE_WIDTH - 1, 0);
    endcase
  endfunction

  function automatic logic [itrd_pkg::BASE_W-1:0] random_base();
    if ($urandom_range(99, 0) < 85) return itrd_pkg::BASE_W'($urandom_range(36, 2));
    if ($urandom_range(1, 0) == 0) return itrd_pkg::BASE_W'($urandom_range(1, 0));
    return itrd_pkg::BASE_W'($urandom_range(63, 37));
  endfunction

  task automatic run_random_items(input int count);
    repeat (count) send_conversion(random_value(), random_base());
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_conversion('0, 6'd10);
    send_conversion('0, 6'd2);
    send_conversion('0, 6'd36);
    send_conversion(ALL_ONES, 6'd2);
    send_conversion(ALL_ONES, 6'd36);
    send_conversion(ALL_ONES, 6'd10);
    send_conversion(ALL_ONES, 6'd16);
    send_conversion(ALL_ONES, 6'd8);
    send_conversion(ALL_ONES, 6'd32);
    send_conversion(ALL_ONES, 6'd3);
    send_conversion(64'd1, 6'd2);
    send_conversion(64'd35, 6'd36);
    send_conversion(64'd36, 6'd36);
    send_conversion(64'd9, 6'd10);
    send_conversion(64'd10, 6'd10);
    send_conversion(64'd15, 6'd16);
    send_conversion(64'h8000_0000_0000_0000, 6'd2);
    send_conversion(64'h1234_5678_9abc_def0, 6'd16);
    send_conversion(64'haaaa_aaaa_aaaa_aaaa, 6'd7);
    send_conversion(64'h5555_5555_5555_5555, 6'd2);
    // Radices outside the legal range each answer with a single error request.
    send_conversion(ALL_ONES, 6'd0);
    send_conversion(ALL_ONES, 6'd1);
    send_conversion('0, 6'd37);
    send_conversion(ALL_ONES, 6'd63);
  endtask

  task automatic test_random_no_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_items(110);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct  = 50;
    recv_stall_pct = 0;
    run_random_items(110);
  endtask

  task automatic test_random_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 50;
    run_random_items(110);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    run_random_items(110);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* integer_to_radix_digits_unit.f */
rtl/itrd_pkg.sv
rtl/itrd_div.sv
rtl/integer_to_radix_digits_unit.sv
tb/sv/integer_to_radix_digits_unit_tb.sv
